@@ rtl/core/uhist_pkg.sv @@
// shared types and constants of the uniform bin histogram core
package uhist_pkg;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int INDEX_W   = 8;
  localparam int NBINS_W   = 9;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS    = 2'd2;

  // transaction actions
  typedef enum logic [1:0] {
    ACT_ADD        = 2'd0,
    ACT_READ       = 2'd1,
    ACT_READ_CLEAR = 2'd2
  } act_t;

  // request from the index stage to the counter bank
  typedef struct packed {
    logic               valid;
    act_t               action;
    logic               drop;
    logic [INDEX_W-1:0] bin_index;
  } req_t;

endpackage

@@ rtl/core/uhist_front.sv @@
// front end: input register, offset subtract, reciprocal multiply and bin index
module uhist_front #(
  parameter int MAX_BINS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    action,
  input  logic [uhist_pkg::DATA_W-1:0]  sample,
  input  logic [uhist_pkg::INDEX_W-1:0] read_index,
  input  logic [uhist_pkg::DATA_W-1:0]  base_offset,
  input  logic [uhist_pkg::DATA_W-1:0]  inv_width,
  input  logic [uhist_pkg::NBINS_W-1:0] num_bins,
  output uhist_pkg::req_t               req,
  output logic [$clog2(MAX_BINS)-1:0]   req_addr
);
  import uhist_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_BINS);

  logic                accept;
  logic                act_ok;
  logic [DATA_W:0]     diff;
  logic [DATA_W-1:0]   mag_next;

  logic                s1_valid;
  act_t                s1_action;
  logic                s1_neg;
  logic [DATA_W-1:0]   s1_mag;
  logic [INDEX_W-1:0]  s1_read_index;

  logic                s2_valid;
  act_t                s2_action;
  logic                s2_neg;
  logic [2*DATA_W-1:0] s2_prod;
  logic [INDEX_W-1:0]  s2_read_index;

  logic [DATA_W-1:0]   idx;
  logic                add_drop;
  logic                read_drop;

  // input transaction and exact signed difference
  always_comb begin
    accept   = start && !busy;
    act_ok   = (action == ACT_ADD) || (action == ACT_READ) || (action == ACT_READ_CLEAR);
    diff     = {sample[DATA_W-1], sample} - {base_offset[DATA_W-1], base_offset};
    mag_next = diff[DATA_W] ? (~diff[DATA_W-1:0] + 32'd1) : diff[DATA_W-1:0];
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && act_ok;
    end
    s1_action     <= act_t'(action);
    s1_neg        <= diff[DATA_W];
    s1_mag        <= mag_next;
    s1_read_index <= read_index;
  end

  // reciprocal multiply, magnitude fits 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_action     <= s1_action;
    s2_neg        <= s1_neg;
    s2_prod       <= s1_mag * inv_width;
    s2_read_index <= s1_read_index;
  end

  // floor to bin index and range checks
  always_comb begin
    idx       = s2_prod[2*DATA_W-1:DATA_W];
    add_drop  = (s2_neg && (s2_prod != '0)) || (idx >= 32'(num_bins))
                || (idx >= 32'(MAX_BINS));
    read_drop = 32'(s2_read_index) >= 32'(MAX_BINS);

    req.valid  = s2_valid;
    req.action = s2_action;
    if (s2_action == ACT_ADD) begin
      req.drop      = add_drop;
      req.bin_index = add_drop ? '0 : idx[INDEX_W-1:0];
      req_addr      = add_drop ? '0 : IDX_BITS'(idx);
    end else begin
      req.drop      = read_drop;
      req.bin_index = s2_read_index;
      req_addr      = read_drop ? '0 : IDX_BITS'(s2_read_index);
    end
  end

endmodule

@@ rtl/core/uhist_bank.sv @@
// counter bank: bin memory, clearing pass, forwarding, update and result register
module uhist_bank #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  uhist_pkg::req_t               req,
  input  logic [$clog2(MAX_BINS)-1:0]   req_addr,
  output logic                          busy,
  output logic                          done,
  output logic [uhist_pkg::INDEX_W-1:0] bin_index,
  output logic [uhist_pkg::DATA_W-1:0]  bin_count,
  output logic                          out_of_range,
  output logic                          saturated
);
  import uhist_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_BINS);

  logic [COUNT_BITS-1:0] mem [MAX_BINS];

  logic                  clearing;
  logic [IDX_BITS-1:0]   clr_addr;

  req_t                  req_q;
  logic [IDX_BITS-1:0]   addr_q;
  logic [COUNT_BITS-1:0] rdata;

  logic                  lw_valid;
  logic [IDX_BITS-1:0]   lw_addr;
  logic [COUNT_BITS-1:0] lw_data;

  logic [COUNT_BITS-1:0] cur;
  logic                  cur_max;
  logic                  wr_item;
  logic [COUNT_BITS-1:0] wr_value;
  logic [DATA_W-1:0]     res_count;
  logic                  res_sat;
  logic                  mem_we;
  logic [IDX_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  assign busy = clearing;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_BITS'(MAX_BINS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // forward the write made in the previous cycle, then update
  always_comb begin
    cur      = (lw_valid && (lw_addr == addr_q)) ? lw_data : rdata;
    cur_max  = &cur;
    wr_item  = 1'b0;
    wr_value = '0;
    res_count = '0;
    res_sat   = 1'b0;
    if (req_q.valid && !req_q.drop) begin
      case (req_q.action)
        ACT_ADD: begin
          wr_item   = 1'b1;
          wr_value  = cur_max ? cur : cur + COUNT_BITS'(1);
          res_count = DATA_W'(wr_value);
          res_sat   = cur_max;
        end
        ACT_READ: begin
          res_count = DATA_W'(cur);
          res_sat   = cur_max;
        end
        ACT_READ_CLEAR: begin
          wr_item   = 1'b1;
          wr_value  = '0;
          res_count = DATA_W'(cur);
          res_sat   = cur_max;
        end
        default: begin
          wr_item = 1'b0;
        end
      endcase
    end
    mem_we    = clearing || wr_item;
    mem_waddr = clearing ? clr_addr : addr_q;
    mem_wdata = clearing ? '0 : wr_value;
  end

  // bin memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[req_addr];
  end

  // request and last write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q.valid <= 1'b0;
      lw_valid    <= 1'b0;
    end else begin
      req_q.valid <= req.valid;
      lw_valid    <= wr_item;
    end
    req_q.action    <= req.action;
    req_q.drop      <= req.drop;
    req_q.bin_index <= req.bin_index;
    addr_q          <= req_addr;
    lw_addr         <= addr_q;
    lw_data         <= wr_value;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_q.valid;
    end
    bin_index    <= req_q.bin_index;
    bin_count    <= res_count;
    out_of_range <= req_q.drop;
    saturated    <= res_sat;
  end

endmodule

@@ rtl/core/uniform_bin_histogram_core.sv @@
// top level of the uniform bin histogram core
// done is registered after the input, multiply, request and result registers
// throughput: one transaction per cycle if not busy, repeats forwarded from last write
// the bin memory, with one read and one write port, sets the rate: one of each per cycle
// reset: synchronous; a clearing pass zeroes every bin, busy held high
// results cannot be stalled: each done strobe lasts exactly one cycle
module uniform_bin_histogram_core #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [uhist_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uhist_pkg::DATA_W-1:0]    cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [uhist_pkg::DATA_W-1:0]    sample,
  input  logic [uhist_pkg::INDEX_W-1:0]   read_index,
  output logic                            done,
  output logic [uhist_pkg::INDEX_W-1:0]   bin_index,
  output logic [uhist_pkg::DATA_W-1:0]    bin_count,
  output logic                            out_of_range,
  output logic                            saturated
);
  import uhist_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_BINS);

  logic [DATA_W-1:0]   base_offset;
  logic [DATA_W-1:0]   inv_width;
  logic [NBINS_W-1:0]  num_bins;
  req_t                req;
  logic [IDX_BITS-1:0] req_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= 32'd0;
      inv_width   <= 32'd65536;
      num_bins    <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_OFFSET: base_offset <= cfg_data;
        CFG_INV_WIDTH:   inv_width   <= cfg_data;
        CFG_NUM_BINS:    num_bins    <= cfg_data[NBINS_W-1:0];
        default: begin
          num_bins <= num_bins;
        end
      endcase
    end
  end

  // index computation
  uhist_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .sample      (sample),
    .read_index  (read_index),
    .base_offset (base_offset),
    .inv_width   (inv_width),
    .num_bins    (num_bins),
    .req         (req),
    .req_addr    (req_addr)
  );

  // counter storage and results
  uhist_bank #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bank (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .req_addr     (req_addr),
    .busy         (busy),
    .done         (done),
    .bin_index    (bin_index),
    .bin_count    (bin_count),
    .out_of_range (out_of_range),
    .saturated    (saturated)
  );

endmodule

@@ rtl/core/uhist_checker.sv @@
// port checker for the uniform bin histogram core and its bind
module uhist_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [1:0]                      action,
  input logic                            done,
  input logic [uhist_pkg::DATA_W-1:0]    bin_count,
  input logic                            out_of_range,
  input logic                            saturated
);
  import uhist_pkg::*;

  // no result while the clearing pass runs
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during clearing pass");

  // busy never comes back once the clearing pass is over
  a_busy_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy raised after clearing pass");

  // every result comes from an earlier accepted transaction
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without matching transaction");

  // every accepted transaction with a valid action gives a result
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_ADD || action == ACT_READ
                        || action == ACT_READ_CLEAR)) |-> ##4 done)
    else $error("transaction lost");

  // a dropped transaction reports an empty count
  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (bin_count == '0 && !saturated))
    else $error("dropped transaction with count");

endmodule

bind uniform_bin_histogram_core uhist_checker u_checker (.*);
